[hdl/scfc_pkg.sv]
// ----------------------------------------------------------------------------
// scfc_pkg
// Shared constants and the CRC byte update for the serial command frame
// checker.
// ----------------------------------------------------------------------------
package scfc_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned CMD_W    = 4;
  localparam int unsigned ADDR_W   = 12;
  localparam int unsigned HDR_W    = CMD_W + ADDR_W;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CRC_W    = 16;

  localparam logic [CRC_W-1:0] XMODEM_POLY = 16'h1021;

  // byte positions within one frame
  localparam logic [POS_W-1:0] POS_PRE0   = 4'd0;
  localparam logic [POS_W-1:0] POS_HDR_HI = 4'd2;
  localparam logic [POS_W-1:0] POS_HDR_LO = 4'd3;
  localparam logic [POS_W-1:0] POS_DATA0  = 4'd4;
  localparam logic [POS_W-1:0] POS_DATA1  = 4'd5;
  localparam logic [POS_W-1:0] POS_DATA2  = 4'd6;
  localparam logic [POS_W-1:0] POS_DATA3  = 4'd7;
  localparam logic [POS_W-1:0] POS_CRC_HI = 4'd8;
  localparam logic [POS_W-1:0] POS_LAST   = 4'd9;

  // msb-first crc-16/xmodem update over one byte
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] acc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    r = acc ^ {b, 8'h00};
    for (int k = 0; k < BYTE_W; k++) begin
      if (r[CRC_W-1]) begin
        r = {r[CRC_W-2:0], 1'b0} ^ XMODEM_POLY;
      end else begin
        r = {r[CRC_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

[hdl/serial_command_frame_checker.sv]
// ----------------------------------------------------------------------------
// serial_command_frame_checker
// Splits a received byte stream into 10-byte reply frames, runs
// CRC-16/XMODEM over the header and data bytes and reports each frame.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_rx_byte, in_frame_start
//  out     | output    | out_valid / out_ready | command, address, data, crc, ok
//
//  one byte per cycle while in_ready is high: each byte updates the frame
//  registers in the cycle it is transferred; the tenth byte loads the
//  result register at its own transfer edge and out_valid is high from
//  the next cycle on. the crc update of one byte is a single combinational
//  step per cycle. synchronous active-low reset returns the frame position
//  to byte 0. in_ready drops only while a result waits and out_ready is low.
module serial_command_frame_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [scfc_pkg::BYTE_W-1:0]         in_rx_byte,
  input  logic                                in_frame_start,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [scfc_pkg::CMD_W-1:0]          out_command_code,
  output logic [scfc_pkg::ADDR_W-1:0]         out_register_address,
  output logic [scfc_pkg::DATA_W-1:0]         out_payload_word,
  output logic [scfc_pkg::CRC_W-1:0]          out_received_check,
  output logic                                out_check_ok
);

  logic [scfc_pkg::POS_W-1:0]  byte_position_r, byte_position_nxt;
  logic [scfc_pkg::CRC_W-1:0]  running_check_r, running_check_nxt;
  logic [scfc_pkg::HDR_W-1:0]  header_word_r, header_word_nxt;
  logic [scfc_pkg::DATA_W-1:0] payload_shift_r, payload_shift_nxt;
  logic [scfc_pkg::BYTE_W-1:0] check_high_byte_r, check_high_byte_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [scfc_pkg::CMD_W-1:0]  out_cmd_r;
  logic [scfc_pkg::ADDR_W-1:0] out_addr_r;
  logic [scfc_pkg::DATA_W-1:0] out_data_r;
  logic [scfc_pkg::CRC_W-1:0]  out_crc_r;
  logic                        out_ok_r;

  logic                        in_xfer;
  logic                        emit;
  logic [scfc_pkg::POS_W-1:0]  pos_cur;
  logic [scfc_pkg::CRC_W-1:0]  crc_in;
  logic [scfc_pkg::CRC_W-1:0]  crc_upd;
  logic [scfc_pkg::CRC_W-1:0]  rx_crc;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    pos_cur = in_frame_start ? scfc_pkg::POS_PRE0 : byte_position_r;
    // unreachable positions fall back to the first preamble byte
    if (pos_cur > scfc_pkg::POS_LAST) begin
      pos_cur = scfc_pkg::POS_PRE0;
    end
  end

  // crc restarts from zero on the header high byte
  assign crc_in  = (pos_cur == scfc_pkg::POS_HDR_HI) ? '0 : running_check_r;
  assign crc_upd = scfc_pkg::crc_byte(crc_in, in_rx_byte);
  assign rx_crc  = {check_high_byte_r, in_rx_byte};
  assign emit    = in_xfer && (pos_cur == scfc_pkg::POS_LAST);

  always_comb begin
    byte_position_nxt   = byte_position_r;
    running_check_nxt   = running_check_r;
    header_word_nxt     = header_word_r;
    payload_shift_nxt   = payload_shift_r;
    check_high_byte_nxt = check_high_byte_r;
    if (in_xfer) begin
      byte_position_nxt = (pos_cur == scfc_pkg::POS_LAST) ? scfc_pkg::POS_PRE0
                                                          : pos_cur + 4'd1;
      unique case (pos_cur)
        scfc_pkg::POS_HDR_HI: begin
          running_check_nxt = crc_upd;
          header_word_nxt   = {in_rx_byte, 8'h00};
        end
        scfc_pkg::POS_HDR_LO: begin
          running_check_nxt = crc_upd;
          header_word_nxt   = {header_word_r[scfc_pkg::HDR_W-1:scfc_pkg::BYTE_W], in_rx_byte};
        end
        scfc_pkg::POS_DATA0, scfc_pkg::POS_DATA1,
        scfc_pkg::POS_DATA2, scfc_pkg::POS_DATA3: begin
          running_check_nxt = crc_upd;
          payload_shift_nxt = {payload_shift_r[scfc_pkg::DATA_W-scfc_pkg::BYTE_W-1:0],
                               in_rx_byte};
        end
        scfc_pkg::POS_CRC_HI: begin
          check_high_byte_nxt = in_rx_byte;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_position_r   <= scfc_pkg::POS_PRE0;
      running_check_r   <= '0;
      header_word_r     <= '0;
      payload_shift_r   <= '0;
      check_high_byte_r <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      byte_position_r   <= byte_position_nxt;
      running_check_r   <= running_check_nxt;
      header_word_r     <= header_word_nxt;
      payload_shift_r   <= payload_shift_nxt;
      check_high_byte_r <= check_high_byte_nxt;
      out_valid_r       <= out_valid_nxt;
    end
  end

  // result register, loaded on the last byte of a frame
  always_ff @(posedge clk) begin
    if (emit) begin
      out_cmd_r  <= header_word_r[scfc_pkg::HDR_W-1:scfc_pkg::ADDR_W];
      out_addr_r <= header_word_r[scfc_pkg::ADDR_W-1:0];
      out_data_r <= payload_shift_r;
      out_crc_r  <= rx_crc;
      out_ok_r   <= (rx_crc == running_check_r);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_command_code     = out_cmd_r;
  assign out_register_address = out_addr_r;
  assign out_payload_word     = out_data_r;
  assign out_received_check   = out_crc_r;
  assign out_check_ok         = out_ok_r;

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_position_r <= scfc_pkg::POS_LAST)
    else $error("frame position out of range");

  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && pos_cur == scfc_pkg::POS_LAST) |=> out_valid_r)
    else $error("last frame byte gave no result");

  a_start_realign: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_frame_start) |=> (byte_position_r == 4'd1))
    else $error("start flag did not realign frame position");

  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !(in_xfer && pos_cur == scfc_pkg::POS_LAST)) |=> !out_valid_r)
    else $error("result appeared without a last frame byte");
`endif

endmodule
